>>> rtl/core/sbamd_pkg.sv
// shared types and codes for the signed byte alu with multiply and divide
// no dependencies
package sbamd_pkg;

    localparam int unsigned OP_W   = 2;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned RES_W  = 16;
    localparam int unsigned STEP_N = 8;
    localparam int unsigned CNT_W  = $clog2(STEP_N);

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIX
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } ctl_t;

    typedef struct packed {
        logic [BYTE_W-1:0] remainder_value;
        logic [RES_W-1:0]  result_value;
    } res_t;

    typedef struct packed {
        logic divide_by_zero;
        res_t data;
    } out_t;

endpackage

>>> rtl/core/sbamd_ctrl.sv
// sequencer: load, eight shared-adder steps for multiply and divide, result fix
// depends on sbamd_pkg
module sbamd_ctrl
    import sbamd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [OP_W-1:0] in_op,
    input  logic            out_free,
    output logic            ready,
    output ctl_t            ctl
);

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               accept;

    assign accept = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    if (in_op == OP_MUL || in_op == OP_DIV)
                        state_next = ST_RUN;
                    else
                        state_next = ST_FIX;
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEP_N - 1))
                    state_next = ST_FIX;
            end
            ST_FIX:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ready      = 1'b0;
        ctl.load   = 1'b0;
        ctl.step   = 1'b0;
        ctl.finish = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ready    = 1'b1;
                ctl.load = in_valid;
            end
            ST_RUN:
            begin
                ctl.step = 1'b1;
            end
            ST_FIX:
            begin
                ctl.finish = out_free;
            end
            default:
            begin
                ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> rtl/core/sbamd_datapath.sv
// operand registers, one shared 9-bit add/subtract unit, shift accumulator
// and sign fixing; depends on sbamd_pkg
module sbamd_datapath
    import sbamd_pkg::*;
(
    input  logic              clk,
    input  ctl_t              ctl,
    input  logic [OP_W-1:0]   in_op,
    input  logic [BYTE_W-1:0] in_a,
    input  logic [BYTE_W-1:0] in_b,
    output out_t              result
);

    op_t                 op_reg;
    logic [BYTE_W-1:0]   a_reg;
    logic [BYTE_W-1:0]   b_reg;
    logic [BYTE_W-1:0]   m_reg;
    logic [RES_W-1:0]    acc_reg;
    logic [RES_W-1:0]    acc_next;

    logic [BYTE_W-1:0]   mag_a;
    logic [BYTE_W-1:0]   mag_b;
    logic [BYTE_W:0]     add_x;
    logic [BYTE_W:0]     add_y;
    logic                add_sub;
    logic [BYTE_W:0]     add_sum;
    logic [BYTE_W-1:0]   r_shift;
    logic [BYTE_W-1:0]   q_mag;
    logic [BYTE_W-1:0]   q_fix;
    logic [BYTE_W-1:0]   r_fix;
    logic                sign_a;
    logic                sign_diff;

    assign mag_a = in_a[BYTE_W-1] ? (BYTE_W'(0) - in_a) : in_a;
    assign mag_b = in_b[BYTE_W-1] ? (BYTE_W'(0) - in_b) : in_b;

    assign sign_a    = a_reg[BYTE_W-1];
    assign sign_diff = a_reg[BYTE_W-1] ^ b_reg[BYTE_W-1];
    assign r_shift   = {acc_reg[RES_W-2:BYTE_W], acc_reg[BYTE_W-1]};

    // shared adder
    always_comb
    begin
        add_x   = {1'b0, a_reg};
        add_y   = {1'b0, b_reg};
        add_sub = (op_reg == OP_SUB);
        if (ctl.step && op_reg == OP_DIV)
        begin
            add_x   = {1'b0, r_shift};
            add_y   = {1'b0, m_reg};
            add_sub = 1'b1;
        end
        else if (ctl.step)
        begin
            add_x   = {1'b0, acc_reg[RES_W-1:BYTE_W]};
            add_y   = {1'b0, m_reg};
            add_sub = 1'b0;
        end
    end

    assign add_sum = add_x + (add_y ^ {(BYTE_W+1){add_sub}}) + {{BYTE_W{1'b0}}, add_sub};

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.load)
        begin
            acc_next = {{BYTE_W{1'b0}}, (in_op == OP_DIV) ? mag_a : mag_b};
        end
        else if (ctl.step && op_reg == OP_DIV)
        begin
            // restoring step: keep the difference when it did not go negative
            if (!add_sum[BYTE_W])
                acc_next = {add_sum[BYTE_W-1:0], acc_reg[BYTE_W-2:0], 1'b1};
            else
                acc_next = {r_shift, acc_reg[BYTE_W-2:0], 1'b0};
        end
        else if (ctl.step)
        begin
            if (acc_reg[0])
                acc_next = RES_W'({add_sum, acc_reg[BYTE_W-1:0]} >> 1);
            else
                acc_next = RES_W'({1'b0, acc_reg[RES_W-1:BYTE_W], acc_reg[BYTE_W-1:0]} >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg <= op_t'(in_op);
            a_reg  <= in_a;
            b_reg  <= in_b;
            m_reg  <= (in_op == OP_DIV) ? mag_b : mag_a;
        end
        acc_reg <= acc_next;
    end

    assign q_mag = acc_reg[BYTE_W-1:0];
    assign q_fix = sign_diff ? (BYTE_W'(0) - q_mag) : q_mag;
    assign r_fix = sign_a ? (BYTE_W'(0) - acc_reg[RES_W-1:BYTE_W])
                          : acc_reg[RES_W-1:BYTE_W];

    always_comb
    begin
        result = '0;
        case (op_reg)
            OP_ADD, OP_SUB:
            begin
                result.data.result_value = {{BYTE_W{add_sum[BYTE_W-1]}}, add_sum[BYTE_W-1:0]};
            end
            OP_MUL:
            begin
                result.data.result_value = sign_diff ? (RES_W'(0) - acc_reg) : acc_reg;
            end
            OP_DIV:
            begin
                if (b_reg == '0)
                begin
                    result.divide_by_zero = 1'b1;
                end
                else
                begin
                    result.data.result_value    = {{BYTE_W{q_fix[BYTE_W-1]}}, q_fix};
                    result.data.remainder_value = r_fix;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/signed_byte_alu_mul_div.sv
// top level: signed byte add, subtract, multiply and divide on stream channels
// depends on sbamd_pkg, sbamd_ctrl, sbamd_datapath
//
// usage
//   input beat: s_axis_tdata carries operand_a (bits 7:0) and operand_b
//   (bits 15:8); s_axis_tuser carries the opcode (0 add, 1 sub, 2 mul, 3 div)
//   output beat: m_axis_tdata carries result_value (bits 15:0) and
//   remainder_value (bits 23:16); m_axis_tuser carries divide_by_zero
//   one output beat for every input beat, in order
//   add and subtract: the operands are registered at accept and the result
//   is written to the output register from the fix state
//   multiply and divide: the work runs as a load, eight steps of the single
//   shared 9-bit add/subtract unit and a sign fix; for every opcode the next
//   beat waits until the sequencer is back in idle
//   s_axis_tready is high only while the sequencer is idle, so at most one
//   beat is in work; the output register lets the next beat enter while a
//   finished result waits
//   if the receiver stalls, the finished result holds in the fix cycle until
//   the output register frees up
//   reset clears the sequencer and the output valid; no result is pending
module signed_byte_alu_mul_div
    import sbamd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // operand_a, operand_b
    input  logic [1:0]  s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // result_value, remainder_value
    output logic [0:0]  m_axis_tuser    // divide_by_zero
);

    ctl_t   ctl;
    out_t   result;
    out_t   out_reg;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_axis_tready;

    sbamd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .out_free (out_free),
        .ready    (s_axis_tready),
        .ctl      (ctl)
    );

    sbamd_datapath u_datapath (
        .clk    (clk),
        .ctl    (ctl),
        .in_op  (s_axis_tuser),
        .in_a   (s_axis_tdata[7:0]),
        .in_b   (s_axis_tdata[15:8]),
        .result (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.finish)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
            out_reg <= result;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_reg.data;
    assign m_axis_tuser[0] = out_reg.divide_by_zero;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted a beat while the previous one was in work");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> m_axis_tvalid)
        else $error("finished result not presented");

    a_finish_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |-> out_free)
        else $error("result written over a pending beat");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("divide by zero with nonzero data");
`endif

endmodule
